// ===== sv/mrcz_pkg.sv =====
// Shared types and constants for the matrix row/column zeroing unit.
// Depends on nothing; every other file of the block imports it.
package mrcz_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int SIZE_W = 7;
    localparam int CMD_W  = 2;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        OP_START,
        OP_LOAD,
        OP_READ,
        OP_READ_OOR
    } op_t;

    typedef struct packed {
        op_t                          op;
        logic [ROW_W-1:0]             row;
        logic [COL_W-1:0]             col;
        logic signed [DATA_WIDTH-1:0] data;
    } queue_entry_t;

endpackage

// ===== sv/mrcz_front.sv =====
// Front end: holds the size registers, decodes commands and range-checks
// positions, and emits work entries. Depends on mrcz_pkg.
module mrcz_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [mrcz_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                          in_accept,
    input  logic [mrcz_pkg::CMD_W-1:0]    command,
    input  logic [mrcz_pkg::ROW_W-1:0]    row_index,
    input  logic [mrcz_pkg::COL_W-1:0]    col_index,
    input  logic signed [31:0]            element_value,
    output logic                          push,
    output mrcz_pkg::queue_entry_t        push_entry
);
    import mrcz_pkg::*;

    logic [SIZE_W-1:0] row_count_reg;
    logic [SIZE_W-1:0] col_count_reg;
    logic              in_size;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= SIZE_RESET;
            col_count_reg <= SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ROW_COUNT)
                row_count_reg <= cfg_data;
            else
                col_count_reg <= cfg_data;
        end
    end

    // A count above the maximum admits every index anyway, so no clamp needed
    assign in_size = ({1'b0, row_index} < row_count_reg) &&
                     ({1'b0, col_index} < col_count_reg);

    always_comb
    begin
        push            = 1'b0;
        push_entry.op   = OP_START;
        push_entry.row  = row_index;
        push_entry.col  = col_index;
        push_entry.data = DATA_WIDTH'(element_value);
        case (command)
            CMD_START:
            begin
                push = in_accept;
            end
            CMD_LOAD:
            begin
                push_entry.op = OP_LOAD;
                push          = in_accept && in_size;
            end
            CMD_READ:
            begin
                push_entry.op = in_size ? OP_READ : OP_READ_OOR;
                push          = in_accept;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/mrcz_queue.sv =====
// Short FIFO of decoded work entries between front and back.
// Depends on mrcz_pkg.
module mrcz_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mrcz_pkg::queue_entry_t push_entry,
    input  logic                   pop,
    output logic                   full,
    output logic                   head_valid,
    output mrcz_pkg::queue_entry_t head_entry
);
    import mrcz_pkg::*;

    queue_entry_t      entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// ===== sv/mrcz_back.sv =====
// Back end: element memory, row/column zero flags, read pipeline and
// output register. Depends on mrcz_pkg.
module mrcz_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  mrcz_pkg::queue_entry_t        head_entry,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            result_value,
    output logic                          out_of_range
);
    import mrcz_pkg::*;

    logic [DATA_WIDTH-1:0] mem [MAX_ROWS * MAX_COLS];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [MAX_ROWS-1:0]   row_zero_reg;
    logic [MAX_COLS-1:0]   col_zero_reg;

    logic                  s1_valid_reg;
    logic                  s1_zero_reg;
    logic                  s1_oor_reg;

    logic                  out_valid_reg;
    logic [31:0]           out_value_reg;
    logic                  out_oor_reg;

    logic                  out_free;
    logic                  s1_free;
    logic                  head_is_read;
    logic [ADDR_W-1:0]     head_addr;
    logic                  do_start;
    logic                  do_load;
    logic                  do_read;

    assign out_free     = !out_valid_reg || !out_stall;
    assign s1_free      = !s1_valid_reg || out_free;
    assign head_is_read = (head_entry.op == OP_READ) || (head_entry.op == OP_READ_OOR);
    // Reads wait for room in the read stage; start and load never wait
    assign pop          = head_valid && (!head_is_read || s1_free);
    assign head_addr    = {head_entry.row, head_entry.col};

    assign do_start = pop && (head_entry.op == OP_START);
    assign do_load  = pop && (head_entry.op == OP_LOAD);
    assign do_read  = pop && (head_entry.op == OP_READ);

    // Element memory: one write or one read per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (do_load)
            mem[head_addr] <= head_entry.data;
        if (do_read)
            rd_data_reg <= mem[head_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_zero_reg <= '0;
            col_zero_reg <= '0;
        end
        else if (do_start)
        begin
            row_zero_reg <= '0;
            col_zero_reg <= '0;
        end
        else if (do_load && (head_entry.data == '0))
        begin
            row_zero_reg[head_entry.row] <= 1'b1;
            col_zero_reg[head_entry.col] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pop && head_is_read)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Sample the flags with the read, since a later load may set them
    always_ff @(posedge clk)
    begin
        if (pop && head_is_read)
        begin
            s1_oor_reg  <= (head_entry.op == OP_READ_OOR);
            s1_zero_reg <= (head_entry.op == OP_READ_OOR) ||
                           row_zero_reg[head_entry.row] ||
                           col_zero_reg[head_entry.col];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_value_reg <= s1_zero_reg ? '0 : 32'(rd_data_reg);
            out_oor_reg   <= s1_oor_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign out_of_range = out_oor_reg;

endmodule

// ===== sv/matrix_row_col_zero_unit.sv =====
// A read result passes from the work queue through the read stage to the output register.
// Throughput: one transaction per cycle; set by the single-port element memory.
// The input stalls only when the four-entry work queue is full.
// Reset (rst_n, async, active low) clears all row/column zero marks, queue and
// pipeline; sizes return to 64x64. Element memory is not cleared.
// Top level of the matrix row/column zeroing unit; depends on mrcz_pkg,
// mrcz_front, mrcz_queue and mrcz_back.
module matrix_row_col_zero_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [mrcz_pkg::SIZE_W-1:0]   cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mrcz_pkg::CMD_W-1:0]    command,
    input  logic [mrcz_pkg::ROW_W-1:0]    row_index,
    input  logic [mrcz_pkg::COL_W-1:0]    col_index,
    input  logic signed [31:0]            element_value,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            result_value,
    output logic                          out_of_range
);
    import mrcz_pkg::*;

    logic         in_accept;
    logic         push;
    queue_entry_t push_entry;
    logic         pop;
    logic         full;
    logic         head_valid;
    queue_entry_t head_entry;

    // Hold the input off only while the queue has no free slot
    assign in_stall  = full;
    assign in_accept = in_valid && !in_stall;

    // Front: decode, range-check, drop ignored transactions
    mrcz_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_accept     (in_accept),
        .command       (command),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .push          (push),
        .push_entry    (push_entry)
    );

    // Queue: decouple the front from output back-pressure
    mrcz_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back: execute start/load/read against marks and memory
    mrcz_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .out_of_range (out_of_range)
    );

endmodule

// ===== sv/mrcz_checker.sv =====
// Port-level checks for matrix_row_col_zero_unit, bound to the top level.
// Depends on mrcz_pkg.
module mrcz_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic signed [31:0]            result_value,
    input  logic                          out_of_range
);
    import mrcz_pkg::*;

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value) && $stable(out_of_range))
        else $error("stalled result changed");

    // An out-of-range read always returns zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> result_value == '0)
        else $error("out-of-range result not zero");

    // Configuration writes are never refused
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

    // The input backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a stalled result");

endmodule

bind matrix_row_col_zero_unit mrcz_checker u_mrcz_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .out_of_range (out_of_range)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for matrix_row_col_zero_unit: directed table, then random phases.
// Depends on mrcz_pkg and the unit's RTL; holds its own model of the zeroing behavior.
module tb_top;

    import mrcz_pkg::*;

    // Unused command code; the unit must ignore it.
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;
    // Queue depth plus the read stage and output register, with margin: loads may still be in flight.
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 14;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        logic signed [31:0] value;
        logic               oor;
    } read_result_t;

    typedef enum logic {
        STIM_TXN,
        STIM_SIZE
    } stim_kind_t;

    typedef struct {
        stim_kind_t         kind;
        logic [CMD_W-1:0]   cmd;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [31:0]        data;
        bit                 typed;
        read_result_t       typed_result;
        logic               reg_sel;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_index;
    logic [SIZE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     command;
    logic [ROW_W-1:0]     row_index;
    logic [COL_W-1:0]     col_index;
    logic signed [31:0]   element_value;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [31:0]   result_value;
    logic                 out_of_range;

    // Model state: element store, sticky zero marks, current sizes.
    logic [31:0]          elem_mem [0:MAX_ROWS*MAX_COLS-1];
    bit                   written [0:MAX_ROWS*MAX_COLS-1];
    int                   written_list [$];
    bit                   row_mark [MAX_ROWS];
    bit                   col_mark [MAX_COLS];
    logic [SIZE_W-1:0]    rows_cfg;
    logic [SIZE_W-1:0]    cols_cfg;

    read_result_t         pending_reads [$];
    read_result_t         head;
    stim_row_t            stim_rows [$];

    int                   errors;
    int                   txns_sent;
    int                   reads_checked;
    int                   size_settings;
    int                   useful_items;
    bit                   no_idle;

    matrix_row_col_zero_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .row_index     (row_index),
        .col_index     (col_index),
        .element_value (element_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value),
        .out_of_range  (out_of_range)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Model of the unit
    // ------------------------------------------------------------------

    // Clamp a size register to the array bound.
    function automatic int eff_rows();
        return (rows_cfg > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg);
    endfunction

    function automatic int eff_cols();
        return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    endfunction

    function automatic bit in_size(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        return (int'(r) < eff_rows()) && (int'(c) < eff_cols());
    endfunction

    // Apply one accepted transaction to the model matrix; report the read result if any.
    task automatic matrix_apply(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
                                input logic [COL_W-1:0] c, input logic [31:0] v,
                                output bit produced, output read_result_t res);
        int addr;
        addr = int'({r, c});
        produced = 1'b0;
        res = '{32'sd0, 1'b0};
        case (cmd)
            CMD_START:
            begin
                foreach (row_mark[i]) row_mark[i] = 1'b0;
                foreach (col_mark[i]) col_mark[i] = 1'b0;
            end
            CMD_LOAD:
            begin
                if (in_size(r, c))
                begin
                    elem_mem[addr] = v;
                    if (!written[addr])
                    begin
                        written[addr] = 1'b1;
                        written_list.push_back(addr);
                    end
                    if (v == 32'd0)
                    begin
                        row_mark[r] = 1'b1;
                        col_mark[c] = 1'b1;
                    end
                end
            end
            CMD_READ:
            begin
                produced = 1'b1;
                if (!in_size(r, c))
                    res = '{32'sd0, 1'b1};
                else if (row_mark[r] || col_mark[c])
                    res = '{32'sd0, 1'b0};
                else
                    res = '{elem_mem[addr], 1'b0};
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one transaction, hold it through stalls, then predict its result.
    task automatic send_txn(input logic [CMD_W-1:0] cmd, input logic [ROW_W-1:0] r,
                            input logic [COL_W-1:0] c, input logic [31:0] v,
                            input bit typed, input read_result_t typed_res);
        bit           produced;
        read_result_t res;
        while (!no_idle && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        row_index     <= r;
        col_index     <= c;
        element_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        txns_sent++;
        matrix_apply(cmd, r, c, v, produced, res);
        if (produced)
            pending_reads.push_back(typed ? typed_res : res);
    endtask

    // Drop valid, wait for every read result, then let in-flight loads retire.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one size register; only called while the unit is idle.
    task automatic write_size(input logic sel, input logic [SIZE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (sel == REG_ROW_COUNT)
            rows_cfg = val;
        else
            cols_cfg = val;
        size_settings++;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed table builders
    // ------------------------------------------------------------------

    task automatic tab_txn(input logic [CMD_W-1:0] cmd, input int r, input int c,
                           input logic [31:0] v);
        stim_row_t s;
        s = '{STIM_TXN, cmd, r[ROW_W-1:0], c[COL_W-1:0], v, 1'b0, '{32'sd0, 1'b0}, 1'b0};
        stim_rows.push_back(s);
    endtask

    task automatic tab_read(input int r, input int c, input logic [31:0] ev, input logic eoor);
        stim_row_t s;
        s = '{STIM_TXN, CMD_READ, r[ROW_W-1:0], c[COL_W-1:0], 32'd0, 1'b1, '{ev, eoor}, 1'b0};
        stim_rows.push_back(s);
    endtask

    task automatic tab_size(input logic sel, input logic [SIZE_W-1:0] val);
        stim_row_t s;
        s = '{STIM_SIZE, CMD_START, '0, '0, 32'(val), 1'b0, '{32'sd0, 1'b0}, sel};
        stim_rows.push_back(s);
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    // Element value: zeros often enough to mark rows, extremes now and then.
    function automatic logic [31:0] rand_word();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10)
            return 32'd0;
        else if (p < 14)
            return 32'h7FFF_FFFF;
        else if (p < 18)
            return 32'h8000_0000;
        else if (p < 21)
            return 32'hFFFF_FFFF;
        else
            return $urandom;
    endfunction

    // Issue one random transaction; count it when the unit does not just ignore it.
    task automatic random_txn();
        int           p;
        int           lr;
        int           lc;
        int           r;
        int           c;
        int           k;
        bit           found;
        read_result_t none;
        none = '{32'sd0, 1'b0};
        lr = eff_rows();
        lc = eff_cols();
        p  = $urandom_range(0, 99);
        r  = $urandom_range(0, MAX_ROWS - 1);
        c  = $urandom_range(0, MAX_COLS - 1);
        if (p < 4)
        begin
            send_txn(CMD_START, ROW_W'(r), COL_W'(c), $urandom, 1'b0, none);
            useful_items++;
        end
        else if (p < 8)
        begin
            send_txn(CMD_NONE, ROW_W'(r), COL_W'(c), $urandom, 1'b0, none);
        end
        else if (p < 14 && (lr < MAX_ROWS || lc < MAX_COLS))
        begin
            // Load outside the size in use: must leave the matrix alone.
            if (lc >= MAX_COLS || (lr < MAX_ROWS && $urandom_range(0, 1)))
                r = $urandom_range(lr, MAX_ROWS - 1);
            else
                c = $urandom_range(lc, MAX_COLS - 1);
            send_txn(CMD_LOAD, ROW_W'(r), COL_W'(c), rand_word(), 1'b0, none);
        end
        else if (p < 56 || lr == 0 || lc == 0)
        begin
            if (lr > 0 && lc > 0)
            begin
                r = $urandom_range(0, lr - 1);
                c = $urandom_range(0, lc - 1);
                send_txn(CMD_LOAD, ROW_W'(r), COL_W'(c), rand_word(), 1'b0, none);
                useful_items++;
            end
            else
            begin
                // Nothing is in range: every read is out of range.
                send_txn(CMD_READ, ROW_W'(r), COL_W'(c), $urandom, 1'b0, none);
                useful_items++;
            end
        end
        else if ($urandom_range(0, 99) < 15 && (lr < MAX_ROWS || lc < MAX_COLS))
        begin
            if (lc >= MAX_COLS || (lr < MAX_ROWS && $urandom_range(0, 1)))
                r = $urandom_range(lr, MAX_ROWS - 1);
            else
                c = $urandom_range(lc, MAX_COLS - 1);
            send_txn(CMD_READ, ROW_W'(r), COL_W'(c), $urandom, 1'b0, none);
            useful_items++;
        end
        else
        begin
            // Read only elements already loaded: look in range, then in the loaded list.
            found = 1'b0;
            for (k = 0; k < 24 && !found; k++)
            begin
                r = $urandom_range(0, lr - 1);
                c = $urandom_range(0, lc - 1);
                found = written[r * MAX_COLS + c];
            end
            for (k = 0; k < 24 && !found && written_list.size() > 0; k++)
            begin
                p = written_list[$urandom_range(0, written_list.size() - 1)];
                r = p / MAX_COLS;
                c = p % MAX_COLS;
                found = (r < lr) && (c < lc);
            end
            if (found)
                send_txn(CMD_READ, ROW_W'(r), COL_W'(c), $urandom, 1'b0, none);
            else
                send_txn(CMD_LOAD, ROW_W'($urandom_range(0, lr - 1)),
                         COL_W'($urandom_range(0, lc - 1)), rand_word(), 1'b0, none);
            useful_items++;
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("result with no read pending: result_value %0d out_of_range %0b",
                       result_value, out_of_range);
                errors++;
            end
            else
            begin
                head = pending_reads.pop_front();
                reads_checked++;
                if (result_value !== head.value)
                begin
                    $error("result_value: expected %0d, got %0d", head.value, result_value);
                    errors++;
                end
                if (out_of_range !== head.oor)
                begin
                    $error("out_of_range: expected %0b, got %0b", head.oor, out_of_range);
                    errors++;
                end
            end
        end
        // Stall the result channel at random, except in the steady stretch.
        out_stall <= !no_idle && ($urandom_range(0, 99) < 38);
    end

    // Watchdog: end the run if it hangs.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int           ph;
        int           lr;
        int           lc;
        int           r;
        int           c;
        int           budget;
        int           half;
        bit           drained;
        logic [SIZE_W-1:0] nr;
        logic [SIZE_W-1:0] nc;
        read_result_t none;

        none          = '{32'sd0, 1'b0};
        errors        = 0;
        txns_sent     = 0;
        reads_checked = 0;
        size_settings = 0;
        useful_items  = 0;
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = CMD_START;
        row_index     = '0;
        col_index     = '0;
        element_value = '0;
        out_stall     = 1'b0;

        // Model reset state matches the unit after reset.
        rows_cfg = SIZE_RESET;
        cols_cfg = SIZE_RESET;
        foreach (row_mark[i]) row_mark[i] = 1'b0;
        foreach (col_mark[i]) col_mark[i] = 1'b0;
        foreach (written[i]) written[i] = 1'b0;
        foreach (elem_mem[i]) elem_mem[i] = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: corners, extremes, sticky marks, ignored commands, range checks.
        tab_txn(CMD_START, 0, 0, 32'd0);
        tab_txn(CMD_LOAD, 0, 0, 32'h7FFF_FFFF);
        tab_txn(CMD_LOAD, 63, 63, 32'h8000_0000);
        tab_txn(CMD_LOAD, 0, 63, 32'hFFFF_FFFF);
        tab_txn(CMD_LOAD, 63, 0, 32'd1);
        tab_read(0, 0, 32'h7FFF_FFFF, 1'b0);
        tab_read(63, 63, 32'h8000_0000, 1'b0);
        tab_read(0, 63, 32'hFFFF_FFFF, 1'b0);
        tab_txn(CMD_LOAD, 5, 7, 32'd0);
        tab_txn(CMD_LOAD, 5, 0, 32'd123);
        tab_read(5, 0, 32'd0, 1'b0);
        // Overwrite the zero: the marks must stick until the next start.
        tab_txn(CMD_LOAD, 5, 7, 32'd99);
        tab_read(5, 7, 32'd0, 1'b0);
        tab_txn(CMD_LOAD, 9, 7, 32'd55);
        tab_read(9, 7, 32'd0, 1'b0);
        // Unused command with a zero payload must not mark anything.
        tab_txn(CMD_NONE, 63, 63, 32'd0);
        tab_txn(CMD_READ, 63, 63, 32'd0);
        tab_txn(CMD_START, 63, 63, 32'hFFFF_FFFF);
        tab_txn(CMD_READ, 5, 7, 32'd0);
        // Shrink to 1x1: loads outside are dropped, reads outside flag the range.
        tab_size(REG_ROW_COUNT, 7'd1);
        tab_size(REG_COL_COUNT, 7'd1);
        tab_txn(CMD_LOAD, 1, 0, 32'd77);
        tab_txn(CMD_LOAD, 0, 1, 32'd0);
        tab_txn(CMD_READ, 0, 0, 32'd0);
        tab_read(63, 63, 32'd0, 1'b1);
        tab_read(0, 1, 32'd0, 1'b1);
        // Size zero admits nothing.
        tab_size(REG_ROW_COUNT, 7'd0);
        tab_read(0, 0, 32'd0, 1'b1);
        // Oversized registers act as the array bound.
        tab_size(REG_ROW_COUNT, 7'd127);
        tab_size(REG_COL_COUNT, 7'd100);
        tab_txn(CMD_READ, 63, 0, 32'd0);

        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == STIM_SIZE)
            begin
                settle();
                write_size(stim_rows[i].reg_sel, stim_rows[i].data[SIZE_W-1:0]);
            end
            else
            begin
                send_txn(stim_rows[i].cmd, stim_rows[i].row, stim_rows[i].col,
                         stim_rows[i].data, stim_rows[i].typed, stim_rows[i].typed_result);
            end
        end

        // Random part: one size setting per phase, mostly small matrices.
        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    nr = 7'd4;
                    nc = 7'd4;
                end
                1:
                begin
                    nr = 7'd1;
                    nc = 7'd1;
                end
                2:
                begin
                    nr = 7'd64;
                    nc = 7'd64;
                end
                3:
                begin
                    nr = 7'd3;
                    nc = 7'd7;
                end
                4:
                begin
                    nr = 7'd0;
                    nc = 7'd6;
                end
                5:
                begin
                    nr = 7'd127;
                    nc = 7'd127;
                end
                6:
                begin
                    nr = 7'd8;
                    nc = 7'd8;
                end
                7:
                begin
                    nr = 7'd5;
                    nc = 7'd100;
                end
                8:
                begin
                    nr = 7'd2;
                    nc = 7'd3;
                end
                9:
                begin
                    nr = 7'd12;
                    nc = 7'd12;
                end
                default:
                begin
                    nr = SIZE_W'($urandom_range(1, 10));
                    nc = SIZE_W'($urandom_range(1, 10));
                end
            endcase
            write_size(REG_ROW_COUNT, nr);
            write_size(REG_COL_COUNT, nc);
            // Hold both sides busy for one whole phase.
            no_idle = (ph == 6);
            lr = eff_rows();
            lc = eff_cols();
            budget  = useful_items + PHASE_ITEMS;
            half    = useful_items + PHASE_ITEMS / 2;
            drained = 1'b0;

            // Every third phase keeps the old marks: size changed mid-matrix.
            if (ph % 3 != 2)
            begin
                send_txn(CMD_START, ROW_W'($urandom), COL_W'($urandom), $urandom, 1'b0, none);
                useful_items++;
                if (lr > 0 && lc > 0 && lr * lc <= 144)
                begin
                    // Load the whole matrix, then read it back element by element.
                    for (r = 0; r < lr; r++)
                        for (c = 0; c < lc; c++)
                        begin
                            send_txn(CMD_LOAD, ROW_W'(r), COL_W'(c), rand_word(), 1'b0, none);
                            useful_items++;
                        end
                    for (r = 0; r < lr; r++)
                        for (c = 0; c < lc; c++)
                        begin
                            send_txn(CMD_READ, ROW_W'(r), COL_W'(c), $urandom, 1'b0, none);
                            useful_items++;
                        end
                end
            end

            while (useful_items < budget)
            begin
                random_txn();
                // Pause the sender once per phase until every read has come back.
                if (!drained && useful_items >= half)
                begin
                    settle();
                    drained = 1'b1;
                end
            end
        end
        no_idle = 1'b0;

        settle();

        $display("summary: %0d transactions accepted, %0d read results checked",
                 txns_sent, reads_checked);
        $display("summary: %0d size register writes, sizes from 0 up to 127 rows and columns",
                 size_settings);
        if (pending_reads.size() != 0)
        begin
            $error("%0d read results never arrived", pending_reads.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
